// File: rtl/gated_frequency_amplitude_meter_macros.svh
// Assertion macros for the gated frequency / amplitude meter checker.
// Depends on signals aclk and aresetn being visible where a macro is used.
`ifndef GATED_FREQUENCY_AMPLITUDE_METER_MACROS_SVH
`define GATED_FREQUENCY_AMPLITUDE_METER_MACROS_SVH

// Property checked only outside reset
`define GFAM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked in every cycle, reset included
`define GFAM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: rtl/gfam_pkg.sv
// Shared types and constants for the gated frequency / amplitude meter.
// No dependencies; used by the top level and its checker.
package gfam_pkg;

    typedef logic [2:0]  op_t;
    typedef logic [1:0]  kind_t;
    typedef logic [15:0] value_t;

    // Input operation codes
    localparam op_t OP_TICK    = 3'd0;
    localparam op_t OP_EDGE    = 3'd1;
    localparam op_t OP_SAMPLE  = 3'd2;
    localparam op_t OP_START_F = 3'd3;
    localparam op_t OP_START_A = 3'd4;
    localparam op_t OP_DC      = 3'd5;

    // Result kinds
    localparam kind_t KIND_FREQ = 2'd0;
    localparam kind_t KIND_PP   = 2'd1;
    localparam kind_t KIND_DC   = 2'd2;

    // Gate modes
    localparam logic MODE_FREQ = 1'b0;
    localparam logic MODE_AMPL = 1'b1;

    localparam value_t GATE_RESET    = 16'd44240;
    localparam logic [11:0] FULL_SCALE_MV = 12'd2500;
    localparam value_t VALUE_MAX     = 16'hFFFF;

endpackage

// File: rtl/gated_frequency_amplitude_meter.sv
// Gated frequency / amplitude meter, top level.
// Depends on gfam_pkg.
//
// Usage:
//   Input channel (s_valid/s_ready, s_op, s_sample) carries gate ticks, signal
//   edges, ADC samples and commands (start frequency gate, start amplitude
//   gate, DC convert). Result channel (m_valid/m_ready, m_kind, m_value)
//   carries one result per closed gate or per DC convert.
//   cfg_we/cfg_wdata write gate_length; write only while the block is idle.
// Result path: a result is registered in the result register, or in the skid
//   register while that stalls, from the closing tick or the DC convert.
// Throughput: one input transfer per cycle while s_ready is high, set by the
//   single register stage of gate state and the one shared millivolt
//   multiplier in front of the result register.
// Reset (aresetn low, synchronous): gate closed, counters cleared, minimum
//   set to all ones, gate_length back to 44240, result channel empty.
// Stall: a two-entry output (result register plus skid register) lets one
//   result wait while the next transfer is still taken; s_ready drops only
//   while the skid register is full, and no result is lost or repeated.
module gated_frequency_amplitude_meter #(
    parameter int ADC_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [11:0] s_sample,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [15:0] m_value
);

    localparam int CODE_W = ADC_BITS + 1;
    localparam int PROD_W = CODE_W + 12;

    // Gate state
    logic [15:0]         gate_length_reg;
    logic [15:0]         tick_count_reg, tick_count_next;
    logic                gate_open_reg, gate_open_next;
    logic                gate_mode_reg, gate_mode_next;
    logic [15:0]         edge_count_reg, edge_count_next;
    logic [ADC_BITS-1:0] sample_max_reg, sample_max_next;
    logic [ADC_BITS-1:0] sample_min_reg, sample_min_next;
    logic                sample_seen_reg, sample_seen_next;

    // Output stage
    logic                out_valid_reg, skid_valid_reg;
    gfam_pkg::kind_t     out_kind_reg, skid_kind_reg;
    gfam_pkg::value_t    out_value_reg, skid_value_reg;

    logic                accept;
    logic [ADC_BITS-1:0] samp;
    logic [15:0]         tick_inc;
    logic                res_valid;
    gfam_pkg::kind_t     res_kind;
    gfam_pkg::value_t    res_value;
    logic                use_dc;
    logic                ampl_ok;
    logic [CODE_W-1:0]   mv_code;
    logic [PROD_W-1:0]   mv_prod;
    logic [PROD_W-1:0]   mv_shift;
    gfam_pkg::value_t    mv_sat;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign samp    = ADC_BITS'(s_sample);
    assign tick_inc = tick_count_reg + 16'd1;

    // Shared millivolt conversion: DC sample or twice the peak-to-peak span
    assign use_dc  = (s_op == gfam_pkg::OP_DC);
    assign ampl_ok = sample_seen_reg && (sample_max_reg >= sample_min_reg);
    always_comb begin
        if (use_dc) begin
            mv_code = CODE_W'(samp);
        end else if (ampl_ok) begin
            mv_code = {sample_max_reg - sample_min_reg, 1'b0};
        end else begin
            mv_code = '0;
        end
        mv_prod  = PROD_W'(mv_code) * PROD_W'(gfam_pkg::FULL_SCALE_MV);
        mv_shift = mv_prod >> ADC_BITS;
        mv_sat   = (mv_shift > PROD_W'(gfam_pkg::VALUE_MAX)) ? gfam_pkg::VALUE_MAX
                                                              : mv_shift[15:0];
    end

    // Decode one transfer: gate state update and optional result
    always_comb begin
        tick_count_next  = tick_count_reg;
        gate_open_next   = gate_open_reg;
        gate_mode_next   = gate_mode_reg;
        edge_count_next  = edge_count_reg;
        sample_max_next  = sample_max_reg;
        sample_min_next  = sample_min_reg;
        sample_seen_next = sample_seen_reg;
        res_valid        = 1'b0;
        res_kind         = gfam_pkg::KIND_FREQ;
        res_value        = edge_count_reg;
        if (accept) begin
            unique case (s_op) inside
                gfam_pkg::OP_TICK: begin
                    if (gate_open_reg) begin
                        tick_count_next = tick_inc;
                        // close on reaching the length, or on wrap to zero
                        if (!(tick_inc < gate_length_reg && tick_inc != 16'd0)) begin
                            gate_open_next  = 1'b0;
                            tick_count_next = '0;
                            edge_count_next = '0;
                            res_valid       = 1'b1;
                            if (gate_mode_reg == gfam_pkg::MODE_FREQ) begin
                                res_kind  = gfam_pkg::KIND_FREQ;
                                res_value = edge_count_reg;
                            end else begin
                                res_kind  = gfam_pkg::KIND_PP;
                                res_value = mv_sat;
                            end
                        end
                    end
                end
                gfam_pkg::OP_EDGE: begin
                    if (gate_open_reg && gate_mode_reg == gfam_pkg::MODE_FREQ &&
                        edge_count_reg != gfam_pkg::VALUE_MAX) begin
                        edge_count_next = edge_count_reg + 16'd1;
                    end
                end
                gfam_pkg::OP_SAMPLE: begin
                    if (gate_open_reg && gate_mode_reg == gfam_pkg::MODE_AMPL) begin
                        if (samp > sample_max_reg) sample_max_next = samp;
                        if (samp < sample_min_reg) sample_min_next = samp;
                        sample_seen_next = 1'b1;
                    end
                end
                gfam_pkg::OP_START_F, gfam_pkg::OP_START_A: begin
                    gate_open_next   = 1'b1;
                    gate_mode_next   = (s_op == gfam_pkg::OP_START_A) ? gfam_pkg::MODE_AMPL
                                                                      : gfam_pkg::MODE_FREQ;
                    tick_count_next  = '0;
                    edge_count_next  = '0;
                    sample_max_next  = '0;
                    sample_min_next  = '1;
                    sample_seen_next = 1'b0;
                end
                gfam_pkg::OP_DC: begin
                    res_valid = 1'b1;
                    res_kind  = gfam_pkg::KIND_DC;
                    res_value = mv_sat;
                end
                default: begin
                    // unused op codes: drop
                end
            endcase
        end
    end

    // Hold gate state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_length_reg <= gfam_pkg::GATE_RESET;
            tick_count_reg  <= '0;
            gate_open_reg   <= 1'b0;
            gate_mode_reg   <= gfam_pkg::MODE_FREQ;
            edge_count_reg  <= '0;
            sample_max_reg  <= '0;
            sample_min_reg  <= '1;
            sample_seen_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                gate_length_reg <= cfg_wdata;
            end
            tick_count_reg  <= tick_count_next;
            gate_open_reg   <= gate_open_next;
            gate_mode_reg   <= gate_mode_next;
            edge_count_reg  <= edge_count_next;
            sample_max_reg  <= sample_max_next;
            sample_min_reg  <= sample_min_next;
            sample_seen_reg <= sample_seen_next;
        end
    end

    // Advance the result register, park a result in the skid register on stall
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= res_valid;
            end
        end else if (res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_kind_reg  <= skid_kind_reg;
                out_value_reg <= skid_value_reg;
            end else begin
                out_kind_reg  <= res_kind;
                out_value_reg <= res_value;
            end
        end else if (res_valid) begin
            skid_kind_reg  <= res_kind;
            skid_value_reg <= res_value;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_kind  = out_kind_reg;
    assign m_value = out_value_reg;

endmodule

// File: rtl/gfam_checker.sv
// Port-level checker for the gated frequency / amplitude meter, with its bind.
// Depends on gfam_pkg and gated_frequency_amplitude_meter_macros.svh.
`include "gated_frequency_amplitude_meter_macros.svh"

module gfam_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [2:0]  s_op,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_kind,
    input logic [15:0] m_value
);

    // Reset empties the result channel and reopens the input
    `GFAM_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid && s_ready, "result after reset")

    // A stalled result holds
    `GFAM_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_value), "stalled result changed")

    // DC convert taken with room downstream answers on the next cycle
    `GFAM_ASSERT(a_dc_answer, s_valid && s_ready && s_op == gfam_pkg::OP_DC && (!m_valid || m_ready) |=> m_valid && m_kind == gfam_pkg::KIND_DC, "DC convert not answered")

    // Ops that never give a result leave an empty channel empty
    `GFAM_ASSERT(a_no_spurious, s_valid && s_ready && !m_valid && (s_op == gfam_pkg::OP_EDGE || s_op == gfam_pkg::OP_SAMPLE || s_op == gfam_pkg::OP_START_F || s_op == gfam_pkg::OP_START_A) |=> !m_valid, "spurious result")

    // DC millivolts stay below full scale
    `GFAM_ASSERT(a_dc_range, m_valid && m_kind == gfam_pkg::KIND_DC |-> m_value < 16'd2500, "DC value out of range")

endmodule

bind gated_frequency_amplitude_meter gfam_checker u_gfam_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_op    (s_op),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_kind  (m_kind),
    .m_value (m_value)
);
